// ----- design/lcs_length_two_sequences_assert.svh -----
// Assertion macros for the longest common subsequence block
`ifndef LCS_LENGTH_TWO_SEQUENCES_ASSERT_SVH
`define LCS_LENGTH_TWO_SEQUENCES_ASSERT_SVH
`ifndef SYNTH
`define LCS_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("lcs: forbidden condition seen");
`define LCS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lcs: implication failed");
`else
`define LCS_ASSERT_NEVER(lbl, expr)
`define LCS_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// ----- design/lcs_pkg.sv -----
// Shared types and constants for the longest common subsequence block
package lcs_pkg;

    localparam logic MODE_A = 1'b0;
    localparam logic MODE_B = 1'b1;

    localparam int   OUT_W   = 8;
    localparam int   OUT_MAX = 255;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic en;     // advance the chain
        logic clr;    // clear the row
        logic wr_en;  // store an A element
    } t_cell_ctrl;

    // Flags that travel with a B element along the chain
    typedef struct packed {
        logic valid;
        logic last;
    } t_tok;

endpackage

// ----- design/lcs_length_two_sequences.sv -----
// Each B element walks a chain of MAX_LEN cells; a result is registered once the
// last B element leaves the chain. Throughput: one B element per cycle, unless a
// stalled result holds the input. An A element waits until every B element in the
// chain has left. The whole chain halts while a result is stalled.
// Reset (synchronous, active low) clears the row, the A count, the flags and the chain tokens;
// stored A elements are not cleared.
module lcs_length_two_sequences #(
    parameter int MAX_LEN    = 128,
    parameter int ELEM_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [31:0] i_value,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_lcs_length,
    output logic        o_a_overflow
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int FW = $clog2(MAX_LEN + 2);
    localparam int EW = (ELEM_WIDTH < 32) ? ELEM_WIDTH : 32;
    localparam int LW = (CW > lcs_pkg::OUT_W) ? CW : lcs_pkg::OUT_W;

    logic [CW-1:0]               r_a_count;
    logic                        r_a_closed;
    logic                        r_ovf;
    logic [FW-1:0]               r_inflight;
    logic                        r_out_valid;
    logic [lcs_pkg::OUT_W-1:0]   r_out_len;
    logic                        r_out_ovf;

    lcs_pkg::t_cell_ctrl         ctrl;
    lcs_pkg::t_tok               chain_tok  [0:MAX_LEN];
    logic [EW-1:0]               chain_b    [0:MAX_LEN];
    logic [CW-1:0]               chain_left [0:MAX_LEN];
    logic [CW-1:0]               chain_diag [0:MAX_LEN];

    logic                        en;
    logic                        acc;
    logic                        a_acc;
    logic                        b_acc;
    logic                        tok_exit;
    logic [CW-1:0]               base;
    logic [LW-1:0]               len_ext;

    always_comb begin
        en         = !(r_out_valid && i_out_stall);
        o_in_stall = !en || (i_mode == lcs_pkg::MODE_A && r_inflight != '0);
        acc        = i_in_valid && !o_in_stall;
        a_acc      = acc && i_mode == lcs_pkg::MODE_A;
        b_acc      = acc && i_mode == lcs_pkg::MODE_B;
        tok_exit   = en && chain_tok[MAX_LEN].valid;
        base       = r_a_closed ? '0 : r_a_count;

        ctrl.en    = en;
        ctrl.clr   = a_acc;
        ctrl.wr_en = a_acc && base < CW'(MAX_LEN);

        len_ext    = LW'(chain_left[MAX_LEN]);
    end

    assign chain_tok[0]  = '{valid: b_acc, last: i_last};
    assign chain_b[0]    = i_value[EW-1:0];
    assign chain_left[0] = '0;
    assign chain_diag[0] = '0;

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        lcs_cell #(
            .IDX (g),
            .CW  (CW),
            .EW  (EW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl),
            .i_a_count (r_a_count),
            .i_wr_idx  (base),
            .i_wr_data (i_value[EW-1:0]),
            .i_tok     (chain_tok[g]),
            .i_b       (chain_b[g]),
            .i_left    (chain_left[g]),
            .i_diag    (chain_diag[g]),
            .o_tok     (chain_tok[g+1]),
            .o_b       (chain_b[g+1]),
            .o_left    (chain_left[g+1]),
            .o_diag    (chain_diag[g+1])
        );
    end

    // A sequence bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_count  <= '0;
            r_a_closed <= 1'b0;
            r_ovf      <= 1'b0;
        end else if (a_acc) begin
            if (base < CW'(MAX_LEN)) begin
                r_a_count <= CW'(base + 1'b1);
                r_ovf     <= r_a_closed ? 1'b0 : r_ovf;
            end else begin
                r_a_count <= base;
                r_ovf     <= 1'b1;
            end
            r_a_closed <= i_last;
        end
    end

    // Count B items still walking the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (b_acc && !tok_exit) begin
            r_inflight <= FW'(r_inflight + 1'b1);
        end else if (!b_acc && tok_exit) begin
            r_inflight <= FW'(r_inflight - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tok_exit && chain_tok[MAX_LEN].last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Saturate the length to the result width
    always_ff @(posedge i_clk) begin
        if (tok_exit && chain_tok[MAX_LEN].last) begin
            r_out_len <= (len_ext > LW'(lcs_pkg::OUT_MAX)) ?
                         lcs_pkg::OUT_W'(lcs_pkg::OUT_MAX) : len_ext[lcs_pkg::OUT_W-1:0];
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_lcs_length = r_out_len;
    assign o_a_overflow = r_out_ovf;

`include "lcs_length_two_sequences_assert.svh"

    `LCS_ASSERT_NEVER(a_inflight_bound, r_inflight > FW'(MAX_LEN + 1))
    `LCS_ASSERT_IMPLY(a_tok_counted, chain_tok[MAX_LEN].valid, r_inflight != '0)
    `LCS_ASSERT_IMPLY(a_ovf_full, r_ovf, r_a_count == CW'(MAX_LEN))

endmodule

// ----- design/lcs_cell.sv -----
// One cell of the LCS chain: holds one A element and its row value
module lcs_cell #(
    parameter int IDX = 0,
    parameter int CW  = 8,
    parameter int EW  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcs_pkg::t_cell_ctrl i_ctrl,
    input  logic [CW-1:0]       i_a_count,
    input  logic [CW-1:0]       i_wr_idx,
    input  logic [EW-1:0]       i_wr_data,
    input  lcs_pkg::t_tok       i_tok,
    input  logic [EW-1:0]       i_b,
    input  logic [CW-1:0]       i_left,
    input  logic [CW-1:0]       i_diag,
    output lcs_pkg::t_tok       o_tok,
    output logic [EW-1:0]       o_b,
    output logic [CW-1:0]       o_left,
    output logic [CW-1:0]       o_diag
);

    logic [EW-1:0]  r_elem;
    logic [CW-1:0]  r_dp;
    lcs_pkg::t_tok  r_tok;
    logic [EW-1:0]  r_b;
    logic [CW-1:0]  r_left;
    logic [CW-1:0]  r_diag;

    logic           active;
    logic [CW-1:0]  n_val;

    always_comb begin
        active = CW'(IDX) < i_a_count;
        if (r_elem == i_b) begin
            n_val = CW'(i_diag + 1'b1);
        end else begin
            n_val = (r_dp > i_left) ? r_dp : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en && i_wr_idx == CW'(IDX)) begin
            r_elem <= i_wr_data;
        end
    end

    // Row value; drop back to zero once the last B element has passed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp <= '0;
        end else if (i_ctrl.clr) begin
            r_dp <= '0;
        end else if (i_ctrl.en && i_tok.valid && active) begin
            r_dp <= i_tok.last ? '0 : n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_ctrl.en) begin
            r_tok <= i_tok;
        end
    end

    // Inactive cells pass the left value straight through
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_b    <= i_b;
            r_left <= active ? n_val : i_left;
            r_diag <= r_dp;
        end
    end

    assign o_tok  = r_tok;
    assign o_b    = r_b;
    assign o_left = r_left;
    assign o_diag = r_diag;

endmodule
